>>> hw/rtl/jsrt_pkg.sv
`timescale 1ns / 1ps
package jsrt_pkg;

    localparam int unsigned PREFIX_UNITS = 3;
    localparam logic [15:0] POS_CAP      = 16'hFFFF;
    localparam int unsigned QUEUE_DEPTH  = 4;
    localparam int unsigned MAX_RES      = 4;
    localparam int unsigned N_PART       = 33;

    localparam logic [2:0] K_KANJI = 3'd0;
    localparam logic [2:0] K_HIRA  = 3'd1;
    localparam logic [2:0] K_KATA  = 3'd2;
    localparam logic [2:0] K_LATIN = 3'd3;
    localparam logic [2:0] K_DIGIT = 3'd4;
    localparam logic [2:0] K_OTHER = 3'd5;

    localparam logic [15:0] LONG_VOWEL = 16'h30FC;

    // particle table: length and up to three units, first unit in the top bits
    localparam logic [1:0] P_LEN [0:N_PART-1] = '{
        2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1, 2'd1,
        2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd1, 2'd1, 2'd1, 2'd2,
        2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1, 2'd1, 2'd3, 2'd2, 2'd2
    };
    localparam logic [47:0] P_TAB [0:N_PART-1] = '{
        {16'h306F, 16'h0, 16'h0}, {16'h304C, 16'h0, 16'h0},
        {16'h3092, 16'h0, 16'h0}, {16'h306B, 16'h0, 16'h0},
        {16'h3067, 16'h0, 16'h0}, {16'h3068, 16'h0, 16'h0},
        {16'h3082, 16'h0, 16'h0}, {16'h3078, 16'h0, 16'h0},
        {16'h3084, 16'h0, 16'h0}, {16'h306E, 16'h0, 16'h0},
        {16'h304B, 16'h0, 16'h0}, {16'h306D, 16'h0, 16'h0},
        {16'h3088, 16'h0, 16'h0}, {16'h306A, 16'h0, 16'h0},
        {16'h3067, 16'h3059, 16'h0}, {16'h307E, 16'h3059, 16'h0},
        {16'h307E, 16'h3057, 16'h305F}, {16'h307E, 16'h305B, 16'h3093},
        {16'h3060, 16'h0, 16'h0}, {16'h305F, 16'h0, 16'h0},
        {16'h3066, 16'h0, 16'h0}, {16'h304B, 16'h3089, 16'h0},
        {16'h307E, 16'h3067, 16'h0}, {16'h3088, 16'h308A, 16'h0},
        {16'h306A, 16'h3069, 16'h0}, {16'h306E, 16'h3067, 16'h0},
        {16'h306E, 16'h306B, 16'h0}, {16'h3051, 16'h3069, 16'h0},
        {16'h3057, 16'h0, 16'h0}, {16'h3070, 16'h0, 16'h0},
        {16'h306A, 16'h304C, 16'h3089}, {16'h305F, 16'h308A, 16'h0},
        {16'h3063, 16'h3066, 16'h0}
    };

    typedef struct packed {
        logic [15:0]      pos;
        logic [2:0]       kind;
        logic [15:0]      start;
        logic [15:0]      units;
        logic [2:0][15:0] head;
        logic             kw;
        logic [15:0]      ks;
        logic [15:0]      ku;
    } t_st;

    typedef struct packed {
        logic [2:0][15:0] b;
        logic [2:0][15:0] l;
        logic [1:0]       n;
    } t_em;

    typedef struct packed {
        t_st st;
        t_em em;
    } t_res;

    // one queue entry: all results of one item
    typedef struct packed {
        logic [2:0]       n;
        logic [3:0][15:0] b;
        logic [3:0][15:0] l;
        logic             has;
        logic             last;
    } t_grp;

    function automatic logic [15:0] sat_add(logic [15:0] a, logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, POS_CAP}) ? POS_CAP : s[15:0];
    endfunction

    function automatic t_em em_add(t_em e, logic [15:0] b, logic [15:0] l);
        t_em r;
        r = e;
        if (e.n < 2'd3) begin
            r.b[e.n] = b;
            r.l[e.n] = l;
            r.n      = e.n + 2'd1;
        end
        return r;
    endfunction

    function automatic logic [2:0] classify(logic [20:0] cp);
        logic [2:0] k;
        k = K_OTHER;
        if (cp > 21'hFFFF) begin
            k = (cp >= 21'h20000 && cp <= 21'h3FFFF) ? K_KANJI : K_OTHER;
        end else if (cp == 21'h3005 || cp == 21'h3006 || cp == 21'h3007 ||
                     cp == 21'h303B || cp == 21'h30F5 || cp == 21'h30F6 ||
                     (cp >= 21'h4E00 && cp <= 21'h9FFF) ||
                     (cp >= 21'h3400 && cp <= 21'h4DBF) ||
                     (cp >= 21'hF900 && cp <= 21'hFAFF)) begin
            k = K_KANJI;
        end else if ((cp >= 21'h3041 && cp <= 21'h3096) ||
                     (cp >= 21'h3099 && cp <= 21'h309E)) begin
            k = K_HIRA;
        end else if ((cp >= 21'h30A1 && cp <= 21'h30FA) ||
                     (cp >= 21'h30FC && cp <= 21'h30FE) ||
                     (cp >= 21'h31F0 && cp <= 21'h31FF) ||
                     (cp >= 21'hFF66 && cp <= 21'hFF9F)) begin
            k = K_KATA;
        end else if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A) ||
                     (cp >= 21'h00C0 && cp <= 21'h024F) ||
                     (cp >= 21'hFF21 && cp <= 21'hFF3A) ||
                     (cp >= 21'hFF41 && cp <= 21'hFF5A)) begin
            k = K_LATIN;
        end else if ((cp >= 21'h30 && cp <= 21'h39) ||
                     (cp >= 21'hFF10 && cp <= 21'hFF19)) begin
            k = K_DIGIT;
        end
        return k;
    endfunction

    function automatic logic is_particle(logic [2:0][15:0] h, logic [1:0] m);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < N_PART; i++) begin
            if (P_LEN[i] == m && P_TAB[i][47:32] == h[0] &&
                (m < 2'd2 || P_TAB[i][31:16] == h[1]) &&
                (m < 2'd3 || P_TAB[i][15:0] == h[2])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic t_res close_run(t_st s);
        t_res       r;
        logic [1:0] n;
        logic [1:0] plen;
        r.st   = s;
        r.em   = '0;
        n      = 2'd0;
        plen   = 2'd0;
        if (s.units != 16'd0) begin
            if (s.kind == K_KANJI) begin
                if (s.kw) begin
                    r.em = em_add(r.em, s.ks, s.ku);
                end
                r.st.kw = 1'b1;
                r.st.ks = s.start;
                r.st.ku = s.units;
            end else if (s.kind == K_HIRA && s.kw) begin
                n = (s.units > 16'(PREFIX_UNITS)) ? 2'(PREFIX_UNITS) : s.units[1:0];
                for (int m = 3; m >= 1; m--) begin
                    if (plen == 2'd0 && 2'(m) <= n && is_particle(s.head, 2'(m))) begin
                        plen = 2'(m);
                    end
                end
                if (plen != 2'd0) begin
                    r.em = em_add(r.em, s.ks, s.ku);
                    r.em = em_add(r.em, s.start, {14'd0, plen});
                    if ({14'd0, plen} < s.units) begin
                        r.em = em_add(r.em, sat_add(s.start, {14'd0, plen}),
                                      s.units - {14'd0, plen});
                    end
                end else if (s.units <= 16'd3) begin
                    r.em = em_add(r.em, s.ks, sat_add(s.ku, s.units));
                end else begin
                    r.em = em_add(r.em, s.ks, sat_add(s.ku, 16'd1));
                    r.em = em_add(r.em, sat_add(s.start, 16'd1), s.units - 16'd1);
                end
                r.st.kw = 1'b0;
            end else begin
                if (s.kw) begin
                    r.em = em_add(r.em, s.ks, s.ku);
                end
                r.st.kw = 1'b0;
                if (s.kind != K_OTHER) begin
                    r.em = em_add(r.em, s.start, s.units);
                end
            end
        end
        r.st.units = 16'd0;
        r.st.kind  = K_OTHER;
        return r;
    endfunction

    function automatic t_res take_point(t_st s, logic [20:0] cp, logic [15:0] step);
        t_res       r;
        logic [2:0] k;
        k = classify(cp);
        if (cp == {5'd0, LONG_VOWEL} && s.units != 16'd0 && s.kind == K_HIRA) begin
            k = K_HIRA;
        end
        r.st = s;
        r.em = '0;
        if (s.units != 16'd0 && k != s.kind) begin
            r = close_run(s);
        end
        if (r.st.units == 16'd0) begin
            r.st.start = r.st.pos;
            r.st.kind  = k;
        end
        if (r.st.units < 16'd3) begin
            r.st.head[r.st.units[1:0]] = cp[15:0];
        end
        r.st.units = sat_add(r.st.units, step);
        r.st.pos   = sat_add(r.st.pos, step);
        return r;
    endfunction

endpackage

>>> hw/rtl/japanese_script_run_tokenizer.sv
`timescale 1ns / 1ps
// channel   ports                                                   beat taken when
// input     i_code_unit, i_last_unit                                push && !full
// result    o_token_begin, o_token_length, o_has_token,
//           o_last_of_text                                          pop && !empty
//
// one code unit per cycle unless full: the front classifies it and updates run state
// the results of one unit (up to four) go as one entry into a four-deep queue
// the back hands out one result beat per cycle from the head entry while popped
// full rises only when four entries wait; either side may stall freely
// synchronous active-low reset empties the queue and clears all run state
module japanese_script_run_tokenizer
    import jsrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_token_begin,
    output logic [15:0] o_token_length,
    output logic        o_has_token,
    output logic        o_last_of_text
);

    logic c_take;
    logic c_wr;
    t_grp c_grp;

    // a unit is taken whenever it is pushed and there is room for its results
    assign c_take = push && !full;

    jsrt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (c_take),
        .i_code_unit (i_code_unit),
        .i_last_unit (i_last_unit),
        .o_wr        (c_wr),
        .o_grp       (c_grp)
    );

    jsrt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (c_wr),
        .i_grp    (c_grp),
        .o_full   (full),
        .o_empty  (empty),
        .i_pop    (pop),
        .o_begin  (o_token_begin),
        .o_length (o_token_length),
        .o_has    (o_has_token),
        .o_last   (o_last_of_text)
    );

endmodule

>>> hw/rtl/jsrt_front.sv
`timescale 1ns / 1ps
module jsrt_front
    import jsrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_take,
    input  logic [15:0] i_code_unit,
    input  logic        i_last_unit,
    output logic        o_wr,
    output t_grp        o_grp
);

    t_st         r_st;
    logic        r_held_v;
    logic [15:0] r_held_u;
    t_st         n_st;
    logic        n_held_v;
    logic [15:0] n_held_u;

    t_res        c_a;
    t_res        c_b;
    t_res        c_c;
    t_st         c_s;
    t_em         c_fl;
    logic        c_done;
    logic        c_use_a;
    logic        c_use_b;
    logic [20:0] c_pair;
    t_grp        c_g;
    logic [2:0]  c_cnt;

    always_comb begin
        c_pair   = 21'h10000 + ({5'd0, r_held_u - 16'hD800} << 10)
                   + {5'd0, i_code_unit - 16'hDC00};
        c_done   = 1'b0;
        c_use_a  = 1'b0;
        c_use_b  = 1'b0;
        n_held_v = 1'b0;
        n_held_u = r_held_u;
        c_a      = '{st: r_st, em: '0};
        if (r_held_v) begin
            c_use_a = 1'b1;
            if (i_code_unit >= 16'hDC00 && i_code_unit <= 16'hDFFF) begin
                c_a    = take_point(r_st, c_pair, 16'd2);
                c_done = 1'b1;
            end else begin
                c_a = take_point(r_st, {5'd0, r_held_u}, 16'd1);
            end
        end
        c_b = '{st: c_a.st, em: '0};
        if (!c_done) begin
            if (i_code_unit >= 16'hD800 && i_code_unit <= 16'hDBFF && !i_last_unit) begin
                n_held_v = 1'b1;
                n_held_u = i_code_unit;
            end else begin
                c_use_b = 1'b1;
                c_b     = take_point(c_a.st, {5'd0, i_code_unit}, 16'd1);
            end
        end
        c_c  = '{st: c_b.st, em: '0};
        c_fl = '0;
        if (i_last_unit) begin
            c_c = close_run(c_b.st);
            if (c_c.st.kw) begin
                c_fl = em_add(c_fl, c_c.st.ks, c_c.st.ku);
            end
        end
        c_s = c_c.st;

        // gather results in order, at most four per item
        c_g   = '0;
        c_cnt = 3'd0;
        for (int i = 0; i < 3; i++) begin
            if (c_use_a && 2'(i) < c_a.em.n && c_cnt < 3'(MAX_RES)) begin
                c_g.b[c_cnt[1:0]] = c_a.em.b[i];
                c_g.l[c_cnt[1:0]] = c_a.em.l[i];
                c_cnt = c_cnt + 3'd1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (c_use_b && 2'(i) < c_b.em.n && c_cnt < 3'(MAX_RES)) begin
                c_g.b[c_cnt[1:0]] = c_b.em.b[i];
                c_g.l[c_cnt[1:0]] = c_b.em.l[i];
                c_cnt = c_cnt + 3'd1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (i_last_unit && 2'(i) < c_c.em.n && c_cnt < 3'(MAX_RES)) begin
                c_g.b[c_cnt[1:0]] = c_c.em.b[i];
                c_g.l[c_cnt[1:0]] = c_c.em.l[i];
                c_cnt = c_cnt + 3'd1;
            end
        end
        if (c_fl.n != 2'd0 && c_cnt < 3'(MAX_RES)) begin
            c_g.b[c_cnt[1:0]] = c_fl.b[0];
            c_g.l[c_cnt[1:0]] = c_fl.l[0];
            c_cnt = c_cnt + 3'd1;
        end
        c_g.has  = (c_cnt != 3'd0);
        c_g.last = i_last_unit;
        c_g.n    = (c_cnt == 3'd0) ? 3'd1 : c_cnt;

        n_st = c_s;
        if (i_last_unit) begin
            n_st      = '0;
            n_st.kind = K_OTHER;
            n_held_v  = 1'b0;
            n_held_u  = 16'd0;
        end
    end

    assign o_wr  = i_take && (c_cnt != 3'd0 || i_last_unit);
    assign o_grp = c_g;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= '{kind: K_OTHER, default: '0};
            r_held_v <= 1'b0;
            r_held_u <= 16'd0;
        end else if (i_take) begin
            r_st     <= n_st;
            r_held_v <= n_held_v;
            r_held_u <= n_held_u;
        end
    end

endmodule

>>> hw/rtl/jsrt_queue.sv
`timescale 1ns / 1ps
module jsrt_queue
    import jsrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr,
    input  t_grp        i_grp,
    output logic        o_full,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [15:0] o_begin,
    output logic [15:0] o_length,
    output logic        o_has,
    output logic        o_last
);

    t_grp       r_q [QUEUE_DEPTH];
    logic [1:0] r_wr;
    logic [1:0] r_rd;
    logic [2:0] r_cnt;
    logic [1:0] r_sub;
    t_grp       c_h;
    logic       c_pop;
    logic       c_end;

    assign c_h      = r_q[r_rd];
    assign o_full   = (r_cnt == 3'(QUEUE_DEPTH));
    assign o_empty  = (r_cnt == 3'd0);
    assign c_pop    = i_pop && !o_empty;
    assign c_end    = ({1'b0, r_sub} == c_h.n - 3'd1);
    assign o_begin  = c_h.b[r_sub];
    assign o_length = c_h.l[r_sub];
    assign o_has    = c_h.has;
    assign o_last   = c_h.last && c_end;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_q[r_wr] <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
            r_sub <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr <= r_wr + 2'd1;
            end
            if (c_pop) begin
                if (c_end) begin
                    r_rd  <= r_rd + 2'd1;
                    r_sub <= 2'd0;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end
            r_cnt <= r_cnt + {2'd0, i_wr} - {2'd0, c_pop && c_end};
        end
    end

endmodule

>>> hw/rtl/jsrt_checker.sv
`timescale 1ns / 1ps
module jsrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_token_begin,
    input logic [15:0] o_token_length,
    input logic        o_has_token,
    input logic        o_last_of_text
);

    a_bare_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_has_token) |-> (o_last_of_text && o_token_length == 16'd0
                                      && o_token_begin == 16'd0))
        else $error("bare marker malformed");

    a_token_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_has_token) |-> (o_token_length != 16'd0))
        else $error("token of zero length");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_token_begin) && $stable(o_token_length)))
        else $error("waiting result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("not empty after reset");

endmodule

bind japanese_script_run_tokenizer jsrt_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_token_begin  (o_token_begin),
    .o_token_length (o_token_length),
    .o_has_token    (o_has_token),
    .o_last_of_text (o_last_of_text)
);
